// File: src/rhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps
package rhsv_pkg;
   localparam int PIX_W          = 8;
   localparam int HUE_W          = 9;
   localparam int SAT_W          = 16;
   localparam int HUE_NUM_W      = 17;
   localparam int NUM_W          = 24;
   localparam int DIV_STAGES_DEF = 4;
   localparam int HUE_SEXTANT    = 60;
   localparam int HUE_FULL       = 360;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_degrees;
      logic [SAT_W-1:0] saturation_frac;
      logic [PIX_W-1:0] value_level;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] rem;
      logic [NUM_W-1:0] work;
      logic [PIX_W-1:0] divisor;
   } div_lane_type;

   typedef struct packed {
      logic             valid;
      logic             gray;
      logic             hue_neg;
      logic [PIX_W-1:0] value;
      div_lane_type     sat;
      div_lane_type     hue;
   } stage_type;
endpackage

// File: src/rgb_to_hsv_pixel_converter_unit.sv
// RGB to HSV pixel converter top level.
// Each result passes the front register, the divider stage registers and the result register in order.
// Throughput: one pixel per cycle while busy is low; busy is a registered copy of reset.
// Depth is set by the pipelined restoring dividers, NUM_W / DIV_STAGES steps per stage.
// Reset clears all valid bits; transactions in flight are dropped; results cannot stall.
`timescale 1ns / 1ps
module rgb_to_hsv_pixel_converter_unit #(
   parameter int DIV_STAGES = rhsv_pkg::DIV_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rhsv_pkg::req_type req_data,
   output logic              rsp_valid,
   output rhsv_pkg::rsp_type rsp_data
);
   import rhsv_pkg::*;

   logic      busy_ff;
   logic      busy_in;
   logic      accept;
   stage_type link [DIV_STAGES+1];

   assign busy_in = reset;
   assign accept  = start && !busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy = busy_ff;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .stage_out (link[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rhsv_div_step #(
         .DIV_STAGES (DIV_STAGES)
      ) u_div_step (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (link[s]),
         .stage_out  (link[s+1])
      );
   end

   rhsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .stage_prev (link[DIV_STAGES]),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, DIV_STAGES + 2))
      else $error("result strobe without matching accepted transaction");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(DIV_STAGES + 2) (rsp_valid || $past(reset, 1) || $past(reset, 2)
         || $past(reset, 3) || $past(reset, DIV_STAGES + 1) || $past(reset, DIV_STAGES + 2)
         || $past(reset, DIV_STAGES) || $past(reset, 4)))
      else $error("accepted transaction produced no result");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue_degrees < HUE_W'(HUE_FULL)))
      else $error("hue out of range");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.saturation_frac == '0)) |-> (rsp_data.hue_degrees == '0))
      else $error("gray pixel with nonzero hue");
endmodule

// File: src/rhsv_front.sv
// Front stage: max, min, delta, hue sector and division operands.
`timescale 1ns / 1ps
module rhsv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rhsv_pkg::req_type req_data,
   output rhsv_pkg::stage_type stage_out
);
   import rhsv_pkg::*;

   stage_type stage_in;
   stage_type stage_ff;

   always_comb begin
      logic [PIX_W-1:0]     r;
      logic [PIX_W-1:0]     g;
      logic [PIX_W-1:0]     b;
      logic [PIX_W-1:0]     mx;
      logic [PIX_W-1:0]     mn;
      logic [PIX_W-1:0]     d;
      logic [10:0]          term;
      logic [HUE_NUM_W-1:0] hue_num;
      logic                 neg;
      r = req_data.red;
      g = req_data.green;
      b = req_data.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d  = mx - mn;
      neg = 1'b0;
      if (r == mx) begin
         neg  = (g < b);
         term = neg ? ({3'b0, b} - {3'b0, g}) : ({3'b0, g} - {3'b0, b});
      end else if (g == mx) begin
         term = {3'b0, b} + {2'b0, d, 1'b0} - {3'b0, r};
      end else begin
         term = {3'b0, r} + {1'b0, d, 2'b0} - {3'b0, g};
      end
      hue_num = {6'b0, term} * HUE_NUM_W'(HUE_SEXTANT);

      stage_in.valid       = accept;
      stage_in.gray        = (d == '0);
      stage_in.hue_neg     = neg;
      stage_in.value       = mx;
      stage_in.sat.rem     = '0;
      stage_in.sat.work    = {d, 16'b0} - {16'b0, d};
      stage_in.sat.divisor = mx;
      stage_in.hue.rem     = '0;
      stage_in.hue.work    = NUM_W'(hue_num);
      stage_in.hue.divisor = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;
endmodule

// File: src/rhsv_div_step.sv
// Divider pipeline stage: several restoring steps on the saturation and hue lanes.
`timescale 1ns / 1ps
module rhsv_div_step #(
   parameter int DIV_STAGES = rhsv_pkg::DIV_STAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rhsv_pkg::stage_type stage_prev,
   output rhsv_pkg::stage_type stage_out
);
   import rhsv_pkg::*;

   localparam int STEPS = NUM_W / DIV_STAGES;

   stage_type stage_in;
   stage_type stage_ff;

   function automatic div_lane_type lane_advance(input div_lane_type lane);
      div_lane_type     l;
      logic [PIX_W:0]   rem_ext;
      l = lane;
      for (int i = 0; i < STEPS; i++) begin
         rem_ext = {l.rem, l.work[NUM_W-1]};
         l.work  = {l.work[NUM_W-2:0], 1'b0};
         if (rem_ext >= {1'b0, l.divisor}) begin
            rem_ext   = rem_ext - {1'b0, l.divisor};
            l.work[0] = 1'b1;
         end
         l.rem = rem_ext[PIX_W-1:0];
      end
      return l;
   endfunction

   always_comb begin
      stage_in     = stage_prev;
      stage_in.sat = lane_advance(stage_prev.sat);
      stage_in.hue = lane_advance(stage_prev.hue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;
endmodule

// File: src/rhsv_back.sv
// Back stage: hue wrap, gray override and result register.
`timescale 1ns / 1ps
module rhsv_back (
   input  logic                clock,
   input  logic                reset,
   input  rhsv_pkg::stage_type stage_prev,
   output logic                rsp_valid,
   output rhsv_pkg::rsp_type   rsp_data
);
   import rhsv_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      logic [HUE_W-1:0] q;
      q = stage_prev.hue.work[HUE_W-1:0];
      rsp_valid_in = stage_prev.valid;
      rsp_in.value_level = stage_prev.value;
      if (stage_prev.gray) begin
         rsp_in.hue_degrees     = '0;
         rsp_in.saturation_frac = '0;
      end else begin
         rsp_in.saturation_frac = stage_prev.sat.work[SAT_W-1:0];
         if (stage_prev.hue_neg && (q != '0)) begin
            rsp_in.hue_degrees = HUE_W'(HUE_FULL) - q;
         end else begin
            rsp_in.hue_degrees = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: tb/sv/testbench.sv
// Testbench for the RGB to HSV pixel converter: directed corners, back-to-back runs, random streams, drain pauses.
`timescale 1ns / 1ps
module testbench;
   import rhsv_pkg::*;

   localparam int SAT_ONE    = 65535;
   localparam int TAIL_WAIT  = 16;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type hsv_expected[$];
   int      pixels_sent     = 0;
   int      results_checked = 0;
   int      gray_results    = 0;
   int      mismatch_count  = 0;

   rgb_to_hsv_pixel_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5ns clock = ~clock;

   function automatic rsp_type hsv_of(input req_type px);
      int      r, g, b, mx, mn, delta, hue;
      rsp_type res;
      r     = px.red;
      g     = px.green;
      b     = px.blue;
      mx    = (r > g) ? r : g;
      mx    = (mx > b) ? mx : b;
      mn    = (r < g) ? r : g;
      mn    = (mn < b) ? mn : b;
      delta = mx - mn;
      hue   = 0;
      res.saturation_frac = '0;
      if (delta != 0) begin
         res.saturation_frac = SAT_W'((delta * SAT_ONE) / mx);
         if (r == mx) begin
            hue = (HUE_SEXTANT * (g - b)) / delta;
            if (hue < 0) hue += HUE_FULL;
         end else if (g == mx) begin
            hue = (HUE_SEXTANT * (b - r) + 2 * HUE_SEXTANT * delta) / delta;
         end else begin
            hue = (HUE_SEXTANT * (r - g) + 4 * HUE_SEXTANT * delta) / delta;
         end
      end
      res.hue_degrees = HUE_W'(hue);
      res.value_level = PIX_W'(mx);
      return res;
   endfunction

   function automatic req_type rgb(input int r, input int g, input int b);
      req_type px;
      px.red   = PIX_W'(r);
      px.green = PIX_W'(g);
      px.blue  = PIX_W'(b);
      return px;
   endfunction

   function automatic int near_level(input int base);
      int v;
      v = base + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   function automatic int edge_or_random();
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) return 0;
      if (pick == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   function automatic req_type random_pixel();
      int base, third, kind;
      base  = $urandom_range(0, 255);
      third = $urandom_range(0, 255);
      kind  = $urandom_range(0, 7);
      case (kind)
         3: return rgb(base, base, base);
         4: return rgb(near_level(base), near_level(base), near_level(base));
         5: begin
            case ($urandom_range(0, 2))
               0: return rgb(base, base, third);
               1: return rgb(base, third, base);
               default: return rgb(third, base, base);
            endcase
         end
         6: return rgb(edge_or_random(), edge_or_random(), edge_or_random());
         default: return rgb($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
      endcase
   endfunction

   function automatic int next_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (hsv_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
                     $time, rsp_data.hue_degrees, rsp_data.saturation_frac,
                     rsp_data.value_level);
            mismatch_count++;
         end else begin
            want = hsv_expected.pop_front();
            check_field("hue_degrees", 16'(want.hue_degrees), 16'(rsp_data.hue_degrees));
            check_field("saturation_frac", want.saturation_frac, rsp_data.saturation_frac);
            check_field("value_level", 16'(want.value_level), 16'(rsp_data.value_level));
            results_checked++;
            if (want.saturation_frac == '0) gray_results++;
         end
      end
      if (!reset && start && !busy) hsv_expected.push_back(hsv_of(req_data));
   end

   // hold start high on return so the next transaction can follow back to back
   task automatic send_pixel(input req_type px);
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      wait (results_checked == pixels_sent);
      @(posedge clock);
   endtask

   task automatic test_corner_pixels();
      req_type corners[$];
      corners = '{rgb(0, 0, 0), rgb(255, 255, 255), rgb(1, 1, 1),
                  rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
                  rgb(255, 255, 0), rgb(255, 0, 255), rgb(0, 255, 255),
                  rgb(200, 100, 101), rgb(255, 0, 5), rgb(255, 0, 1),
                  rgb(1, 0, 0), rgb(0, 1, 0), rgb(0, 0, 1),
                  rgb(255, 254, 254), rgb(254, 255, 254), rgb(254, 254, 255),
                  rgb(170, 85, 170), rgb(85, 170, 85), rgb(128, 64, 32),
                  rgb(32, 64, 128), rgb(100, 200, 100), rgb(255, 128, 0)};
      foreach (corners[i]) begin
         send_pixel(corners[i]);
         idle_for(i % 3);
      end
      drain_results();
   endtask

   task automatic test_back_to_back();
      repeat (120) send_pixel(random_pixel());
      drain_results();
   endtask

   task automatic test_drain_pause();
      repeat (8) begin
         repeat ($urandom_range(1, 6)) send_pixel(random_pixel());
         drain_results();
         idle_for($urandom_range(0, 5));
      end
   endtask

   task automatic test_random_stream();
      bit gapless;
      repeat (16) begin
         gapless = ($urandom_range(0, 3) == 0);
         repeat (40) begin
            send_pixel(random_pixel());
            if (!gapless) idle_for(next_gap());
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_corner_pixels();
      test_back_to_back();
      test_drain_pause();
      test_random_stream();
      start <= 1'b0;
      wait (results_checked == pixels_sent);
      repeat (TAIL_WAIT) @(posedge clock);
      $display("Sent %0d pixels and checked %0d results (%0d gray), covering ties,",
               pixels_sent, results_checked, gray_results);
      $display("all three max channels, hue wrap, and both gapped and gapless streams.");
      if (mismatch_count == 0 && hsv_expected.size() == 0) begin
         $display("rgb_to_hsv_pixel_converter_unit test passed");
      end else begin
         $display("rgb_to_hsv_pixel_converter_unit test failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("rgb_to_hsv_pixel_converter_unit test failed");
      $finish;
   end
endmodule
